// ===== sv/rpd_pkg.sv =====
// Shared types, codes and constants of the resource pressure dispatcher.
package rpd_pkg;
  localparam int DEPTH_DEFAULT = 32;
  localparam logic [1:0] KIND_MEASURE = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_REG = 2'd2;
  localparam logic [1:0] KIND_UNREG = 2'd3;
  localparam logic [1:0] RES_SUMMARY = 2'd0;
  localparam logic [1:0] RES_CALL = 2'd1;
  localparam logic [1:0] RES_QUERY = 2'd2;
  localparam logic [1:0] RES_STATUS = 2'd3;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [2:0] REG_PAGE_NOTE = 3'd0;
  localparam logic [2:0] REG_PAGE_WARN = 3'd1;
  localparam logic [2:0] REG_PAGE_CRIT = 3'd2;
  localparam logic [2:0] REG_MEM_NOTE = 3'd3;
  localparam logic [2:0] REG_MEM_WARN = 3'd4;
  localparam logic [2:0] REG_MEM_CRIT = 3'd5;
  localparam logic [47:0] SPACE_NOTE = 48'd134217728;
  localparam logic [47:0] SPACE_WARN = 48'd67108864;
  localparam logic [47:0] SPACE_CRIT = 48'd33554432;

  typedef struct packed {
    logic [15:0] id;
    logic [3:0] mask;
    logic [31:0] prio;
  } entry_t;

  // Command from the sequencer to every cell of the table.
  typedef struct packed {
    logic ins;          // insert new entry
    logic rem;          // remove matched entry
    logic rot;          // rotate for a dispatch scan
    logic [15:0] id;
    logic [3:0] mask;
    logic [31:0] prio;
  } cell_cmd_t;

  function automatic logic [1:0] classify(input logic [47:0] v, input logic [47:0] crit,
                                          input logic [47:0] warn, input logic [47:0] note);
    if (v < crit) return 2'd3;
    if (v < warn) return 2'd2;
    if (v < note) return 2'd1;
    return 2'd0;
  endfunction

  function automatic logic [1:0] level_over(input logic [3:0] m, input logic [7:0] lv);
    logic [1:0] s;
    s = 2'd0;
    for (int i = 0; i < 4; i++)
      if (m[i] && lv[2*i +: 2] > s) s = lv[2*i +: 2];
    return s;
  endfunction
endpackage

// ===== sv/rpd_if.sv =====
// Valid/ready channel interfaces for input items, result items and configuration writes.
interface rpd_in_if;
  logic valid, ready;
  logic [1:0] kind;
  logic [31:0] free_pages;
  logic [47:0] free_memory;
  logic [31:0] used_sems;
  logic [31:0] max_sems;
  logic [47:0] free_space;
  logic [3:0] resource_mask;
  logic [15:0] handler_id;
  logic signed [31:0] priority_req;
  modport source(output valid, kind, free_pages, free_memory, used_sems, max_sems,
                 free_space, resource_mask, handler_id, priority_req, input ready);
  modport sink(input valid, kind, free_pages, free_memory, used_sems, max_sems,
               free_space, resource_mask, handler_id, priority_req, output ready);
endinterface

interface rpd_out_if;
  logic valid, ready;
  logic [1:0] result_kind, pages_level, memory_level, sems_level, space_level;
  logic [3:0] low_mask;
  logic [1:0] level;
  logic [15:0] called_id;
  logic [3:0] called_mask;
  logic [1:0] status;
  logic last;
  modport source(output valid, result_kind, pages_level, memory_level, sems_level,
                 space_level, low_mask, level, called_id, called_mask, status, last,
                 input ready);
  modport sink(input valid, result_kind, pages_level, memory_level, sems_level,
               space_level, low_mask, level, called_id, called_mask, status, last,
               output ready);
endinterface

interface rpd_cfg_if;
  logic valid, ready;
  logic [2:0] index;
  logic [47:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== sv/resource_pressure_dispatcher.sv =====
// Top level of the resource pressure dispatcher: sequencer, levels and result register.
// Usage: items enter on in_ch (valid/ready) and results leave on out_ch. The user writes
// limit registers on cfg_ch only while the block is idle; the block itself does not
// enforce this. A measure item gives a summary and, when any level is above normal, one
// call per subscriber whose mask meets the low mask, in priority order. A query gives one
// answer; register and unregister give one status. The subscriber table is a row of cells.
// Register and unregister act on all cells in the same cycle; a dispatch rotates the row
// one slot per cycle, held while the receiver stalls, until it is back in order. After
// accept an item passes through EXEC, which loads the first result into the output
// register; a measure item with calls then goes through SCAN, and each item ends in DONE.
// One item is in work at a time; the next is accepted once the final result of the current
// item has been taken. Results sit in an output register; while the receiver stalls the
// scan holds. Reset clears levels, low mask, fill count and configuration; table entries
// are left undefined, which is safe since only slots below the fill count are read.
module resource_pressure_dispatcher import rpd_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input logic clk,
  input logic rst,
  rpd_in_if.sink in_ch,
  rpd_out_if.source out_ch,
  rpd_cfg_if.sink cfg_ch
);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state, state_next;
  logic [31:0] pn, pw, pc;
  logic [47:0] mn, mw, mc;
  logic [7:0] lv, lv_next;
  logic [3:0] lowm, lowm_next;
  logic [CW-1:0] count, count_next, scan, scan_next;
  logic [1:0] kind;
  logic [3:0] rmask;
  logic [15:0] rid;
  logic [31:0] rprio;
  logic [31:0] fpg, usd, mxs;
  logic [47:0] fmem, fsp;
  cell_cmd_t cmd;
  entry_t head;
  logic found;
  logic ovalid, ovalid_next;
  logic [3:0] shared;
  logic [31:0] fsem;
  logic [7:0] nl;
  logic [3:0] nm;
  logic [1:0] all;
  logic [DEPTH-1:0] share, rest;
  logic more;
  logic load;
  logic [1:0] result_kind_next, pages_level_next, memory_level_next;
  logic [1:0] sems_level_next, space_level_next, level_next, status_next;
  logic [3:0] low_mask_next, called_mask_next;
  logic [15:0] called_id_next;
  logic last_next;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready = (state == S_IDLE) && !ovalid;
  assign out_ch.valid = ovalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      pn <= '0; pw <= '0; pc <= '0; mn <= '0; mw <= '0; mc <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_PAGE_NOTE: pn <= cfg_ch.data[31:0];
        REG_PAGE_WARN: pw <= cfg_ch.data[31:0];
        REG_PAGE_CRIT: pc <= cfg_ch.data[31:0];
        REG_MEM_NOTE:  mn <= cfg_ch.data;
        REG_MEM_WARN:  mw <= cfg_ch.data;
        REG_MEM_CRIT:  mc <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign fsem = mxs - usd;
  assign shared = head.mask & lowm;

  // Levels of the held measurement; they become the state when a measure item executes.
  always_comb begin
    nl[1:0] = classify({16'd0, fpg}, {16'd0, pc}, {16'd0, pw}, {16'd0, pn});
    nl[3:2] = classify(fmem, mc, mw, mn);
    nl[5:4] = classify({16'd0, fsem}, {32'd0, mxs[31:16]}, {24'd0, mxs[31:8]},
                       {20'd0, mxs[31:4]});
    nl[7:6] = classify(fsp, SPACE_CRIT, SPACE_WARN, SPACE_NOTE);
    for (int i = 0; i < 4; i++) nm[i] = |nl[2*i +: 2];
    all = level_over(4'hF, nl);
  end

  // Slots behind the head that are still to be scanned.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) rest[i] = (i >= 1) && (CW'(i) < scan);
  end
  assign more = |(share & rest);

  always_comb begin
    cmd = '{ins: 1'b0, rem: 1'b0, rot: 1'b0, id: rid, mask: rmask, prio: rprio};
    if (state == S_EXEC && kind == KIND_REG && CW'(DEPTH) != count) cmd.ins = 1'b1;
    if (state == S_EXEC && kind == KIND_UNREG) cmd.rem = 1'b1;
    if (state == S_SCAN && (!ovalid || out_ch.ready)) cmd.rot = 1'b1;
  end

  rpd_table #(.DEPTH(DEPTH)) u_table (
    .clk(clk), .cmd(cmd), .count(count), .low((state == S_EXEC) ? nm : lowm),
    .head(head), .found(found), .share(share)
  );

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      kind <= in_ch.kind; rmask <= in_ch.resource_mask; rid <= in_ch.handler_id;
      rprio <= in_ch.priority_req; fpg <= in_ch.free_pages; fmem <= in_ch.free_memory;
      usd <= in_ch.used_sems; mxs <= in_ch.max_sems; fsp <= in_ch.free_space;
    end
  end

  always_comb begin
    state_next = state;
    ovalid_next = ovalid && !out_ch.ready;
    lv_next = lv;
    lowm_next = lowm;
    count_next = count;
    scan_next = scan;
    load = 1'b0;
    result_kind_next = RES_STATUS;
    level_next = 2'd0;
    called_id_next = '0;
    called_mask_next = '0;
    status_next = ST_OK;
    last_next = 1'b1;
    pages_level_next = lv[1:0];
    memory_level_next = lv[3:2];
    sems_level_next = lv[5:4];
    space_level_next = lv[7:6];
    low_mask_next = lowm;
    case (state)
      S_IDLE: if (in_ch.valid && in_ch.ready) state_next = S_EXEC;
      S_EXEC: begin
        load = 1'b1;
        ovalid_next = 1'b1;
        state_next = S_DONE;
        case (kind)
          KIND_MEASURE: begin
            lv_next = nl; lowm_next = nm;
            result_kind_next = RES_SUMMARY; level_next = all;
            pages_level_next = nl[1:0]; memory_level_next = nl[3:2];
            sems_level_next = nl[5:4]; space_level_next = nl[7:6];
            low_mask_next = nm;
            // The summary is the final result unless some subscriber is to be called.
            if (all != 2'd0 && (|share)) begin
              last_next = 1'b0; scan_next = count; state_next = S_SCAN;
            end
          end
          KIND_QUERY: begin
            result_kind_next = RES_QUERY; level_next = level_over(rmask, lv);
          end
          KIND_REG: begin
            if (CW'(DEPTH) == count) status_next = ST_FULL;
            else count_next = count + 1'b1;
          end
          default: begin
            if (found) count_next = count - 1'b1;
            else status_next = ST_NOT_FOUND;
          end
        endcase
      end
      S_SCAN: if (cmd.rot) begin
        // The previous result has been taken; look at the head entry. The row keeps
        // rotating after the final call so that it ends in its original order.
        scan_next = scan - 1'b1;
        if (shared != 4'd0) begin
          load = 1'b1; ovalid_next = 1'b1; result_kind_next = RES_CALL;
          level_next = level_over(shared, lv); called_id_next = head.id;
          called_mask_next = shared; last_next = !more;
        end
        if (scan == CW'(1)) state_next = S_DONE;
      end
      S_DONE: if (!ovalid || out_ch.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; ovalid <= 1'b0; lv <= '0; lowm <= '0; count <= '0; scan <= '0;
    end else begin
      state <= state_next; ovalid <= ovalid_next; lv <= lv_next; lowm <= lowm_next;
      count <= count_next; scan <= scan_next;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst && load) begin
      out_ch.result_kind <= result_kind_next;
      out_ch.pages_level <= pages_level_next;
      out_ch.memory_level <= memory_level_next;
      out_ch.sems_level <= sems_level_next;
      out_ch.space_level <= space_level_next;
      out_ch.low_mask <= low_mask_next;
      out_ch.level <= level_next;
      out_ch.called_id <= called_id_next;
      out_ch.called_mask <= called_mask_next;
      out_ch.status <= status_next;
      out_ch.last <= last_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst) in_ch.ready |-> !out_ch.valid)
    else $error("input accepted while a result waits");
  assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("fill count above depth");
  assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid)
    else $error("result dropped under stall");
endmodule

// ===== sv/rpd_cell.sv =====
// One table cell: holds an entry and shifts, inserts or rotates with its neighbors.
module rpd_cell import rpd_pkg::*; (
  input  logic clk,
  input  cell_cmd_t cmd,
  input  logic in_use,       // this slot is below the fill count
  input  logic left_valid,   // a left neighbor exists
  input  entry_t left_ent,
  input  logic left_ge,      // left neighbor prio >= new prio
  input  entry_t right_ent,
  input  logic left_hit,     // some cell to the left matches the removal id
  input  logic is_last,      // slot at fill count minus one (rotation wrap source)
  input  entry_t wrap_ent,   // entry at slot zero, fed to the last used slot
  output entry_t ent,
  output logic ge,           // entry prio >= new prio (signed)
  output logic hit           // entry id equals the removal id
);
  entry_t ent_next;
  logic here_ge;

  assign here_ge = in_use && ($signed(ent.prio) >= $signed(cmd.prio));
  assign ge = here_ge;
  assign hit = in_use && (ent.id == cmd.id);

  always_comb begin
    ent_next = ent;
    if (cmd.ins) begin
      // Sorted insert: entries after the place move one slot right.
      if (!here_ge) begin
        if (!left_valid || left_ge) ent_next = '{id: cmd.id, mask: cmd.mask, prio: cmd.prio};
        else ent_next = left_ent;
      end
    end else if (cmd.rem) begin
      if (left_hit || hit) ent_next = right_ent;
    end else if (cmd.rot) begin
      if (is_last) ent_next = wrap_ent;
      else ent_next = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent <= ent_next;
  end
endmodule

// ===== sv/rpd_table.sv =====
// Row of table cells with prefix logic for insert position and first match.
module rpd_table import rpd_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic clk,
  input  cell_cmd_t cmd,
  input  logic [CW-1:0] count,
  input  logic [3:0] low,
  output entry_t head,
  output logic found,
  output logic [DEPTH-1:0] share
);
  entry_t ents [DEPTH];
  logic [DEPTH-1:0] ge, hit, prefix;

  // A hit is already sorted by slot, so prefix marks slots after the first match.
  always_comb begin
    prefix[0] = 1'b0;
    for (int i = 1; i < DEPTH; i++) prefix[i] = prefix[i-1] | hit[i-1];
  end
  assign found = |hit;
  assign head = ents[0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic lv, lge, last_slot;
    entry_t le, re;
    assign lv = (i > 0);
    assign le = ents[(i > 0) ? i - 1 : 0];
    assign lge = (i > 0) ? ge[(i > 0) ? i - 1 : 0] : 1'b0;
    assign re = ents[(i < DEPTH - 1) ? i + 1 : i];
    assign last_slot = (CW'(i + 1) == count);
    // A used slot whose mask meets the low mask leads to a call.
    assign share[i] = (CW'(i) < count) && (|(ents[i].mask & low));
    rpd_cell u_cell (
      .clk(clk), .cmd(cmd), .in_use(CW'(i) < count), .left_valid(lv), .left_ent(le),
      .left_ge(lge), .right_ent(re), .left_hit(prefix[i]), .is_last(last_slot),
      .wrap_ent(ents[0]), .ent(ents[i]), .ge(ge[i]), .hit(hit[i])
    );
  end
endmodule

// ===== verif/rpd_sb.sv =====
// Scoreboard class for the resource pressure dispatcher: level predictor and result check.
`timescale 1ns / 100ps
package rpd_sb_pkg;
  import rpd_pkg::*;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [1:0] pages_level;
    logic [1:0] memory_level;
    logic [1:0] sems_level;
    logic [1:0] space_level;
    logic [3:0] low_mask;
    logic [1:0] level;
    logic [15:0] called_id;
    logic [3:0] called_mask;
    logic [1:0] status;
    logic last;
  } res_t;

  class rpd_scoreboard;
    logic [47:0] limits[6];
    logic [1:0] lv[4];
    logic [3:0] low_bits;
    logic [15:0] sub_id[$];
    logic [3:0] sub_mask[$];
    logic signed [31:0] sub_prio[$];
    res_t pending[$];
    int errors;
    int calls_seen;

    function void reset_state();
      foreach (limits[i]) limits[i] = '0;
      foreach (lv[i]) lv[i] = '0;
      low_bits = '0;
      sub_id.delete();
      sub_mask.delete();
      sub_prio.delete();
      pending.delete();
      errors = 0;
      calls_seen = 0;
    endfunction

    function void write_limit(int idx, logic [47:0] v);
      if (idx < 3) limits[idx] = {16'd0, v[31:0]};
      else if (idx < 6) limits[idx] = v;
    endfunction

    function logic [1:0] grade(logic [47:0] v, logic [47:0] c, logic [47:0] w,
                               logic [47:0] n);
      if (v < c) return 2'd3;
      if (v < w) return 2'd2;
      if (v < n) return 2'd1;
      return 2'd0;
    endfunction

    function logic [1:0] worst(logic [3:0] m);
      logic [1:0] s;
      s = 0;
      for (int i = 0; i < 4; i++) if (m[i] && lv[i] > s) s = lv[i];
      return s;
    endfunction

    function void push(logic [1:0] k, logic [1:0] l, logic [15:0] id, logic [3:0] cm,
                       logic [1:0] st);
      res_t r;
      r.result_kind = k;
      r.pages_level = lv[0];
      r.memory_level = lv[1];
      r.sems_level = lv[2];
      r.space_level = lv[3];
      r.low_mask = low_bits;
      r.level = l;
      r.called_id = id;
      r.called_mask = cm;
      r.status = st;
      r.last = 0;
      pending.push_back(r);
    endfunction

    function void note_item(logic [1:0] kind, logic [31:0] pages, logic [47:0] mem,
                            logic [31:0] used, logic [31:0] maxs, logic [47:0] space,
                            logic [3:0] rmask, logic [15:0] id, logic signed [31:0] prio);
      logic [31:0] freesems;
      logic [1:0] all;
      logic [3:0] shared;
      int pos;
      int found;
      case (kind)
        KIND_MEASURE: begin
          freesems = maxs - used;
          lv[0] = grade({16'd0, pages}, limits[2], limits[1], limits[0]);
          lv[1] = grade(mem, limits[5], limits[4], limits[3]);
          lv[2] = grade({16'd0, freesems}, {16'd0, maxs >> 16}, {16'd0, maxs >> 8},
                        {16'd0, maxs >> 4});
          lv[3] = grade(space, SPACE_CRIT, SPACE_WARN, SPACE_NOTE);
          for (int i = 0; i < 4; i++) low_bits[i] = (lv[i] != 0);
          all = worst(4'hf);
          push(RES_SUMMARY, all, 0, 0, ST_OK);
          if (all != 0)
            foreach (sub_id[i]) begin
              shared = sub_mask[i] & low_bits;
              if (shared != 0) push(RES_CALL, worst(shared), sub_id[i], shared, ST_OK);
            end
        end
        KIND_QUERY: push(RES_QUERY, worst(rmask), 0, 0, ST_OK);
        KIND_REG: begin
          if (sub_id.size() >= DEPTH_DEFAULT) push(RES_STATUS, 0, 0, 0, ST_FULL);
          else begin
            pos = 0;
            for (int j = sub_id.size(); j > 0; j--)
              if (sub_prio[j-1] >= prio) begin
                pos = j;
                break;
              end
            sub_id.insert(pos, id);
            sub_mask.insert(pos, rmask);
            sub_prio.insert(pos, prio);
            push(RES_STATUS, 0, 0, 0, ST_OK);
          end
        end
        default: begin
          found = -1;
          foreach (sub_id[i]) if (found < 0 && sub_id[i] == id) found = i;
          if (found >= 0) begin
            sub_id.delete(found);
            sub_mask.delete(found);
            sub_prio.delete(found);
          end
          push(RES_STATUS, 0, 0, 0, found >= 0 ? ST_OK : ST_NOT_FOUND);
        end
      endcase
      pending[$].last = 1;
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got.result_kind == RES_CALL) calls_seen++;
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
      end
    endfunction
  endclass
endpackage

// ===== verif/rpd_tb_if.sv =====
// Testbench constants: the cycle limit of the run.
`timescale 1ns / 100ps
package rpd_tb_cfg_pkg;
  localparam int LIMIT_CYCLES = 1000000;
endpackage

// ===== verif/tb.sv =====
// Testbench top: drives items, limits and receiver stalls, checks every result in order.
`timescale 1ns / 100ps
module tb;
  import rpd_pkg::*;
  import rpd_sb_pkg::*;
  import rpd_tb_cfg_pkg::*;

  logic clk = 0;
  logic rst = 1;
  int cycles = 0;
  int send_idle = 0;
  int stall = 0;
  rpd_scoreboard board;

  rpd_in_if in_ch();
  rpd_out_if out_ch();
  rpd_cfg_if cfg_ch();

  resource_pressure_dispatcher uut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
                                    .cfg_ch(cfg_ch));

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // Receiver: random stalls, every accepted result goes to the scoreboard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb failed");
      $finish;
    end
    if (!rst) begin
      if (out_ch.valid && out_ch.ready)
        board.check_result({out_ch.result_kind, out_ch.pages_level, out_ch.memory_level,
                            out_ch.sems_level, out_ch.space_level, out_ch.low_mask,
                            out_ch.level, out_ch.called_id, out_ch.called_mask,
                            out_ch.status, out_ch.last});
      out_ch.ready <= ($urandom_range(99) >= stall);
    end else begin
      out_ch.ready <= 1'b0;
    end
  end

  // Valid stays high after the write; the caller drops it after the last one.
  task automatic write_limit(logic [2:0] idx, logic [47:0] v);
    cfg_ch.valid <= 1;
    cfg_ch.index <= idx;
    cfg_ch.data <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    board.write_limit(idx, v);
  endtask

  // Valid stays high after the item is taken unless the sender idles or drains.
  task automatic send(logic [1:0] k, logic [31:0] pg, logic [47:0] mem, logic [31:0] used,
                      logic [31:0] maxs, logic [47:0] sp, logic [3:0] m, logic [15:0] id,
                      logic [31:0] pr);
    if ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_ch.valid <= 1;
    in_ch.kind <= k;
    in_ch.free_pages <= pg;
    in_ch.free_memory <= mem;
    in_ch.used_sems <= used;
    in_ch.max_sems <= maxs;
    in_ch.free_space <= sp;
    in_ch.resource_mask <= m;
    in_ch.handler_id <= id;
    in_ch.priority_req <= pr;
    do @(posedge clk); while (!in_ch.ready);
    board.note_item(k, pg, mem, used, maxs, sp, m, id, pr);
  endtask

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  // Values clustered around the space and semaphore thresholds so all levels show up.
  task automatic send_measure();
    logic [31:0] maxs;
    logic [31:0] used;
    logic [47:0] sp;
    maxs = ($urandom_range(3) == 0) ? $urandom : $urandom_range(1 << 20);
    case ($urandom_range(4))
      0: used = maxs - (maxs >> $urandom_range(20));
      1: used = $urandom;
      default: used = $urandom_range(maxs);
    endcase
    sp = ($urandom_range(3) == 0) ? rand48() : 48'($urandom_range(200 << 20));
    send(KIND_MEASURE, ($urandom_range(1)) ? $urandom : $urandom_range(5000),
         ($urandom_range(1)) ? rand48() : 48'($urandom_range(1 << 24)), used, maxs, sp,
         4'($urandom), 16'($urandom), $urandom);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic set_limits(int style);
    logic [47:0] v[6];
    case (style)
      0: foreach (v[i]) v[i] = 48'hffff_ffff_ffff;
      1: foreach (v[i]) v[i] = 0;
      default: begin
        v[2] = 48'($urandom_range(1000));
        v[1] = v[2] + 48'($urandom_range(2000));
        v[0] = v[1] + 48'($urandom_range(2000));
        v[5] = 48'($urandom_range(1 << 22));
        v[4] = v[5] + 48'($urandom_range(1 << 22));
        v[3] = v[4] + 48'($urandom_range(1 << 22));
      end
    endcase
    for (int i = 0; i < 6; i++) write_limit(3'(i), v[i]);
    cfg_ch.valid <= 0;
  endtask

  initial begin
    in_ch.valid <= 0;
    in_ch.kind <= 0;
    in_ch.free_pages <= 0;
    in_ch.free_memory <= 0;
    in_ch.used_sems <= 0;
    in_ch.max_sems <= 0;
    in_ch.free_space <= 0;
    in_ch.resource_mask <= 0;
    in_ch.handler_id <= 0;
    in_ch.priority_req <= 0;
    cfg_ch.valid <= 0;
    cfg_ch.index <= 0;
    cfg_ch.data <= 0;
    board = new();
    board.reset_state();
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    set_limits(0);
    // Directed: empty table, register extremes and ties, full table, removal.
    send(KIND_UNREG, 0, 0, 0, 0, 0, 0, 16'h1234, 0);
    send(KIND_MEASURE, 32'hffff_ffff, 48'hffff_ffff_ffff, 0, 32'hffff_ffff,
         48'hffff_ffff_ffff, 0, 0, 0);
    for (int i = 0; i < 33; i++)
      send(KIND_REG, 0, 0, 0, 0, 0, 4'(i), (i == 5) ? 16'hffff : 16'(i),
           (i % 3 == 0) ? 32'sh7fff_ffff : ((i % 3 == 1) ? 32'sh8000_0000 : 0));
    send(KIND_MEASURE, 0, 0, 0, 0, 0, 4'hf, 0, 0);
    send(KIND_MEASURE, 100, 100, 10, 5, 48'd100, 0, 0, 0);
    for (int q = 0; q < 16; q++) send(KIND_QUERY, 0, 0, 0, 0, 0, 4'(q), 0, 0);
    send(KIND_UNREG, 0, 0, 0, 0, 0, 0, 16'hffff, 0);
    send(KIND_UNREG, 0, 0, 0, 0, 0, 0, 16'h0003, 0);
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      set_limits(ph == 1 ? 1 : (ph == 0 ? 0 : 2));
      send_idle = (ph == 1 || ph == 4) ? 63 : (ph == 3 ? 25 : 0);
      stall = (ph == 2 || ph == 4) ? 63 : (ph == 3 ? 25 : 0);
      for (int n = 0; n < 9; n++)
        case ($urandom_range(9))
          0, 1, 2, 3: send_measure();
          4: send(KIND_QUERY, $urandom, rand48(), $urandom, $urandom, rand48(),
                  4'($urandom), 16'($urandom), $urandom);
          5, 6: send(KIND_REG, $urandom, rand48(), $urandom, $urandom, rand48(),
                     4'($urandom), 16'($urandom_range(40)),
                     ($urandom_range(1)) ? $urandom : $urandom_range(3));
          default: send(KIND_UNREG, $urandom, rand48(), $urandom, $urandom, rand48(),
                        4'($urandom),
                        16'(($urandom_range(5) == 0) ? $urandom : $urandom_range(40)),
                        $urandom);
        endcase
      drain();
    end
    if (board.errors == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end
endmodule
